>>> rtl/core/jtc_pkg.sv
package jtc_pkg;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 20;
    localparam int START_W  = 14;
    localparam int CLASS_W  = 3;
    localparam int LIMIT_W  = 16;
    localparam int PREFIX_W = 40;
    localparam int WLEN_W   = 3;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [LIMIT_W-1:0] SPAN_LIMIT_RESET = 16'd1024;

    // The three constant words, packed with the first letter in the high byte.
    localparam logic [PREFIX_W-1:0] WORD_TRUE  = 40'h00_7472_7565;
    localparam logic [PREFIX_W-1:0] WORD_NULL  = 40'h00_6E75_6C6C;
    localparam logic [PREFIX_W-1:0] WORD_FALSE = 40'h66_616C_7365;
    localparam logic [WLEN_W-1:0]   WLEN_FOUR  = 3'd4;
    localparam logic [WLEN_W-1:0]   WLEN_FIVE  = 3'd5;
    localparam logic [WLEN_W-1:0]   WLEN_SAT   = 3'd6;

    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_MINUS     = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_DOT       = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_E_LOWER   = 8'h65;
    localparam logic [BYTE_W-1:0] CH_E_UPPER   = 8'h45;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;

    typedef enum logic [4:0] {
        KIND_IDLE   = 5'b00001,
        KIND_TEXT   = 5'b00010,
        KIND_STRING = 5'b00100,
        KIND_NUMBER = 5'b01000,
        KIND_WORD   = 5'b10000
    } kind_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_TEXT   = 3'd0,
        CLS_STRING = 3'd1,
        CLS_NUMBER = 3'd2,
        CLS_CONST  = 3'd3,
        CLS_PUNCT  = 3'd4,
        CLS_OPER   = 3'd5
    } token_class_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [POS_W-1:0]   length;
        token_class_t       cls;
        logic               last;
    } span_t;

    // Spans produced by one byte: count is 0, 1 or 2, slot0 goes out first.
    typedef struct packed {
        logic [1:0] count;
        span_t      slot1;
        span_t      slot0;
    } span_pair_t;

    function automatic logic is_numeral(input logic [BYTE_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_bracket(input logic [BYTE_W-1:0] c);
        return c inside {CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET};
    endfunction

    function automatic logic is_operator(input logic [BYTE_W-1:0] c);
        return c inside {CH_COLON, CH_COMMA};
    endfunction

    // A byte that ends a text run and opens another token.
    function automatic logic starts_token(input logic [BYTE_W-1:0] c);
        return (c == CH_QUOTE) || is_numeral(c) || is_word_char(c) || is_bracket(c)
            || is_operator(c);
    endfunction

    function automatic logic is_number_char(input logic [BYTE_W-1:0] c);
        return is_numeral(c) || (c inside {CH_DOT, CH_E_LOWER, CH_E_UPPER, CH_PLUS, CH_MINUS});
    endfunction

    function automatic token_class_t word_class(input logic [PREFIX_W-1:0] prefix,
                                                input logic [WLEN_W-1:0]   wlen);
        if ((wlen == WLEN_FOUR && (prefix == WORD_TRUE || prefix == WORD_NULL))
            || (wlen == WLEN_FIVE && prefix == WORD_FALSE))
        begin
            return CLS_CONST;
        end
        return CLS_TEXT;
    endfunction

endpackage

>>> rtl/core/jtc_lexer.sv
module jtc_lexer #(
    parameter int LONG_LINE_LIMIT = 16384
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [jtc_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                       fire,
    input  logic [jtc_pkg::BYTE_W-1:0] text_byte,
    input  logic [jtc_pkg::POS_W-1:0]  line_length,
    output jtc_pkg::span_pair_t        spans
);
    import jtc_pkg::*;

    localparam logic [POS_W-1:0] LIMIT = POS_W'(LONG_LINE_LIMIT);

    kind_t                kind_reg, kind_next;
    logic [POS_W-1:0]     start_reg, start_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 esc_reg, esc_next;
    logic                 minus_reg, minus_next;
    logic [PREFIX_W-1:0]  prefix_reg, prefix_next;
    logic [WLEN_W-1:0]    wlen_reg, wlen_next;
    logic [LIMIT_W-1:0]   emitted_reg, emitted_next;
    logic [LIMIT_W-1:0]   span_limit_reg;

    logic                 is_long;
    logic                 is_last;
    logic [POS_W:0]       pos_inc;
    logic [POS_W-1:0]     minus_pos;
    logic [POS_W-1:0]     close_end;
    logic                 do_close;
    logic                 do_dispatch;
    logic [2:0]           cand_valid;
    span_t [2:0]          cand;
    logic [1:0]           n_out;
    span_t [1:0]          slot;

    assign pos_inc   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign minus_pos = pos_reg - POS_W'(1);
    assign is_long   = line_length >= LIMIT;
    assign is_last   = pos_inc >= {1'b0, line_length};

    always_comb
    begin
        kind_next    = kind_reg;
        start_next   = start_reg;
        esc_next     = esc_reg;
        minus_next   = minus_reg;
        prefix_next  = prefix_reg;
        wlen_next    = wlen_reg;
        pos_next     = pos_inc[POS_W-1:0];
        emitted_next = emitted_reg;
        do_close     = 1'b0;
        do_dispatch  = 1'b0;
        close_end    = pos_reg;
        cand_valid   = '0;
        cand         = '0;
        n_out        = '0;
        slot         = '0;

        // Lex the byte: at most one closing span and one single-byte span.
        if (!is_long)
        begin
            if (minus_reg)
            begin
                minus_next = 1'b0;
                if (is_numeral(text_byte))
                begin
                    if (kind_next == KIND_TEXT)
                    begin
                        cand_valid[0] = 1'b1;
                        cand[0].start  = start_next[START_W-1:0];
                        cand[0].length = minus_pos - start_next;
                        cand[0].cls    = CLS_TEXT;
                    end
                    kind_next  = KIND_NUMBER;
                    start_next = minus_pos;
                end
                else
                begin
                    if (kind_next != KIND_TEXT)
                    begin
                        kind_next  = KIND_TEXT;
                        start_next = minus_pos;
                    end
                    if (starts_token(text_byte))
                    begin
                        do_close    = 1'b1;
                        do_dispatch = 1'b1;
                    end
                    else if (text_byte == CH_MINUS)
                    begin
                        minus_next = 1'b1;
                    end
                end
            end
            else
            begin
                case (kind_reg)
                    KIND_STRING:
                    begin
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                        end
                        else if (text_byte == CH_BACKSLASH)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (text_byte == CH_QUOTE)
                        begin
                            do_close  = 1'b1;
                            close_end = pos_inc[POS_W-1:0];
                        end
                    end
                    KIND_NUMBER:
                    begin
                        if (!is_number_char(text_byte))
                        begin
                            do_close    = 1'b1;
                            do_dispatch = 1'b1;
                        end
                    end
                    KIND_WORD:
                    begin
                        if (is_word_char(text_byte))
                        begin
                            if (wlen_reg < WLEN_FIVE)
                            begin
                                prefix_next = {prefix_reg[PREFIX_W-BYTE_W-1:0], text_byte};
                            end
                            if (wlen_reg < WLEN_SAT)
                            begin
                                wlen_next = wlen_reg + WLEN_W'(1);
                            end
                        end
                        else
                        begin
                            do_close    = 1'b1;
                            do_dispatch = 1'b1;
                        end
                    end
                    KIND_TEXT:
                    begin
                        if (starts_token(text_byte))
                        begin
                            do_close    = 1'b1;
                            do_dispatch = 1'b1;
                        end
                        else if (text_byte == CH_MINUS)
                        begin
                            minus_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        do_dispatch = 1'b1;
                    end
                endcase
            end

            if (do_close && kind_next != KIND_IDLE)
            begin
                cand_valid[0]  = 1'b1;
                cand[0].start  = start_next[START_W-1:0];
                cand[0].length = close_end - start_next;
                cand[0].cls    = (kind_next == KIND_STRING) ? CLS_STRING :
                                 (kind_next == KIND_NUMBER) ? CLS_NUMBER :
                                 (kind_next == KIND_WORD)   ? word_class(prefix_next, wlen_next) :
                                                              CLS_TEXT;
                kind_next = KIND_IDLE;
            end

            if (do_dispatch)
            begin
                if (text_byte == CH_QUOTE)
                begin
                    kind_next  = KIND_STRING;
                    start_next = pos_reg;
                    esc_next   = 1'b0;
                end
                else if (is_numeral(text_byte))
                begin
                    kind_next  = KIND_NUMBER;
                    start_next = pos_reg;
                end
                else if (text_byte == CH_MINUS)
                begin
                    minus_next = 1'b1;
                end
                else if (is_word_char(text_byte))
                begin
                    kind_next   = KIND_WORD;
                    start_next  = pos_reg;
                    prefix_next = PREFIX_W'(text_byte);
                    wlen_next   = WLEN_W'(1);
                end
                else if (is_bracket(text_byte) || is_operator(text_byte))
                begin
                    cand_valid[1]  = 1'b1;
                    cand[1].start  = pos_reg[START_W-1:0];
                    cand[1].length = POS_W'(1);
                    cand[1].cls    = is_bracket(text_byte) ? CLS_PUNCT : CLS_OPER;
                end
                else
                begin
                    kind_next  = KIND_TEXT;
                    start_next = pos_reg;
                end
            end
        end

        // End of line: flush whatever is open, or report a long line whole.
        if (is_last)
        begin
            if (is_long)
            begin
                cand_valid[2]  = 1'b1;
                cand[2].start  = '0;
                cand[2].length = line_length;
                cand[2].cls    = CLS_TEXT;
            end
            else
            begin
                if (minus_next && kind_next != KIND_TEXT)
                begin
                    kind_next  = KIND_TEXT;
                    start_next = pos_reg;
                end
                if (kind_next != KIND_IDLE)
                begin
                    cand_valid[2]  = 1'b1;
                    cand[2].start  = start_next[START_W-1:0];
                    cand[2].length = pos_inc[POS_W-1:0] - start_next;
                    cand[2].cls    = (kind_next == KIND_STRING) ? CLS_STRING :
                                     (kind_next == KIND_NUMBER) ? CLS_NUMBER :
                                     (kind_next == KIND_WORD)   ?
                                         word_class(prefix_next, wlen_next) : CLS_TEXT;
                end
            end
        end

        // Keep candidates in order, up to two per byte and within the line's cap.
        for (int i = 0; i < 3; i++)
        begin
            if (cand_valid[i] && emitted_next < span_limit_reg && n_out < 2'd2)
            begin
                slot[n_out[0]] = cand[i];
                n_out          = n_out + 2'd1;
                emitted_next   = emitted_next + LIMIT_W'(1);
            end
        end
        if (n_out == 2'd1)
        begin
            slot[0].last = 1'b1;
        end
        else if (n_out == 2'd2)
        begin
            slot[1].last = 1'b1;
        end

        if (is_last)
        begin
            kind_next    = KIND_IDLE;
            start_next   = '0;
            pos_next     = '0;
            esc_next     = 1'b0;
            minus_next   = 1'b0;
            prefix_next  = '0;
            wlen_next    = '0;
            emitted_next = '0;
        end
    end

    assign spans.count = n_out;
    assign spans.slot0 = slot[0];
    assign spans.slot1 = slot[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_IDLE;
            start_reg   <= '0;
            pos_reg     <= '0;
            esc_reg     <= 1'b0;
            minus_reg   <= 1'b0;
            prefix_reg  <= '0;
            wlen_reg    <= '0;
            emitted_reg <= '0;
        end
        else if (fire)
        begin
            kind_reg    <= kind_next;
            start_reg   <= start_next;
            pos_reg     <= pos_next;
            esc_reg     <= esc_next;
            minus_reg   <= minus_next;
            prefix_reg  <= prefix_next;
            wlen_reg    <= wlen_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_limit_reg <= SPAN_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            span_limit_reg <= cfg_wr_data;
        end
    end

endmodule

>>> rtl/core/jtc_span_queue.sv
module jtc_span_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  jtc_pkg::span_pair_t wr_spans,
    output logic                room2,
    output logic                out_valid,
    input  logic                out_ready,
    output jtc_pkg::span_t      out_span
);
    import jtc_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    span_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic [1:0]         wr_n;
    logic               rd;

    // Room is judged without the read of this cycle, which keeps the path short.
    assign room2     = count_reg <= (PTR_W+1)'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_span  = mem[rd_ptr_reg];
    assign rd        = out_valid && out_ready;
    assign wr_n      = wr_en ? wr_spans.count : 2'd0;

    always_ff @(posedge clk)
    begin
        if (wr_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr_spans.slot0;
        end
        if (wr_n == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= wr_spans.slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(wr_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(rd);
            count_reg  <= count_reg + (PTR_W+1)'(wr_n) - (PTR_W+1)'(rd);
        end
    end

endmodule

>>> rtl/core/json_token_classifier.sv
// JSON line tokenizer. The bytes of one text line enter on the slave stream,
// one byte per beat, each carrying the length of its line. The block cuts the
// line into classified spans (text, string, number, constant, punctuation,
// operator) so that every byte lies in exactly one span, and sends one span
// per beat on the master stream; m_tlast marks the last span caused by a byte.
// A byte causes zero, one or two spans. Lines at or above LONG_LINE_LIMIT
// bytes are reported as one text span at their last byte. cfg_wr_en/cfg_wr_data
// set the most spans reported per line; write it only while the block is idle.
//
// A byte accepted on the slave side waits in the input register until it is
// lexed; its spans then go into the span queue that feeds the master side.
// Throughput: one byte per cycle while the span queue has room for two spans,
// set by the single lexing step; the master side moves one span per cycle, so
// the four-entry span queue absorbs the second span of a byte that yields two.
//
// Reset clears all line state and sets the span limit to 1024. When the
// receiver stalls, the queue fills, lexing pauses once fewer than two entries
// are free, the input register holds its byte and s_tready falls.
module json_token_classifier #(
    parameter int LONG_LINE_LIMIT = 16384
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, from bit 0: text_byte[7:0], line_length[27:8], zero fill [31:28]
    input  logic [jtc_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, from bit 0: span_start[13:0], span_length[33:14],
    // token_class[36:34], zero fill [39:37]
    output logic [jtc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // m_tlast carries last_of_run
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [jtc_pkg::LIMIT_W-1:0]         cfg_wr_data
);
    import jtc_pkg::*;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic [POS_W-1:0]    in_len_reg;
    logic                lex_fire;
    logic                room2;
    span_pair_t          spans;
    span_t               out_span;

    // The input register refills in the same cycle that its byte is lexed.
    assign lex_fire = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || lex_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_len_reg  <= s_tdata[BYTE_W+POS_W-1:BYTE_W];
        end
    end

    jtc_lexer #(
        .LONG_LINE_LIMIT (LONG_LINE_LIMIT)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (lex_fire),
        .text_byte   (in_byte_reg),
        .line_length (in_len_reg),
        .spans       (spans)
    );

    jtc_span_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (lex_fire),
        .wr_spans  (spans),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_span  (out_span)
    );

    assign m_tdata = {(OUT_TDATA_W - START_W - POS_W - CLASS_W)'(0),
                      out_span.cls, out_span.length, out_span.start};
    assign m_tlast = out_span.last;

endmodule

>>> rtl/core/jtc_checker.sv
module jtc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [jtc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast
);
    import jtc_pkg::*;

    localparam int CLS_LO = START_W + POS_W;
    localparam int PAD_LO = CLS_LO + CLASS_W;

    // A span offered to a stalled receiver stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("span beat withdrawn while stalled");

    // A stalled span beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("span beat changed while stalled");

    // Only the six defined token classes ever leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[PAD_LO-1:CLS_LO] <= CLASS_W'(CLS_OPER))
        else $error("undefined token class on span beat");

    // The fill bits above the class stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:PAD_LO] == '0)
        else $error("nonzero fill bits on span beat");

endmodule

bind json_token_classifier jtc_checker u_jtc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> verif/span_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the register port. Every byte accepted on the
// slave side runs through a cycle-free model of the lexer, and the spans it
// must cause are queued; every span beat on the master side is checked
// against the oldest queued span.
module span_checker #(
    parameter int LONG_LINE_LIMIT = 16384
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [jtc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [jtc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [jtc_pkg::LIMIT_W-1:0]     cfg_wr_data,
    output int                              mismatches,
    output int                              spans_due
);
    import jtc_pkg::*;

    typedef enum logic [2:0] {
        G_QUOTE,
        G_DIGIT,
        G_MINUS,
        G_WORD,
        G_BRACKET,
        G_OPER,
        G_OTHER
    } byte_group_t;

    logic [LIMIT_W-1:0]  span_cap   = SPAN_LIMIT_RESET;
    kind_t               tok_kind   = KIND_IDLE;
    logic [POS_W-1:0]    tok_start  = '0;
    logic [POS_W-1:0]    pos        = '0;
    logic                in_escape  = 1'b0;
    logic                held_minus = 1'b0;
    logic [PREFIX_W-1:0] word_bits  = '0;
    logic [WLEN_W-1:0]   word_len   = '0;
    logic [LIMIT_W-1:0]  line_spans = '0;
    span_t               step_spans [2];
    int                  step_count;
    span_t               pending_spans [$];
    span_t               oldest;

    function automatic byte_group_t group_of(input logic [BYTE_W-1:0] c);
        if (c == CH_QUOTE)
            return G_QUOTE;
        if (c >= 8'h30 && c <= 8'h39)
            return G_DIGIT;
        if (c == CH_MINUS)
            return G_MINUS;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDERSCORE)
            return G_WORD;
        if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACKET || c == CH_RBRACKET)
            return G_BRACKET;
        if (c == CH_COLON || c == CH_COMMA)
            return G_OPER;
        return G_OTHER;
    endfunction

    // At most two spans leave per byte, and none once the line has hit the cap.
    task automatic emit(input logic [POS_W-1:0] from, input logic [POS_W-1:0] len,
                        input token_class_t cls);
        span_t s;
        if (line_spans < span_cap && step_count < 2)
        begin
            s.start  = from[START_W-1:0];
            s.length = len;
            s.cls    = cls;
            s.last   = 1'b0;
            step_spans[step_count] = s;
            step_count++;
            line_spans++;
        end
    endtask

    task automatic close_open(input logic [POS_W-1:0] end_pos);
        token_class_t cls;
        cls = CLS_TEXT;
        if (tok_kind != KIND_IDLE)
        begin
            case (tok_kind)
                KIND_STRING: cls = CLS_STRING;
                KIND_NUMBER: cls = CLS_NUMBER;
                KIND_WORD:
                begin
                    if ((word_len == WLEN_FOUR && (word_bits == WORD_TRUE || word_bits == WORD_NULL))
                        || (word_len == WLEN_FIVE && word_bits == WORD_FALSE))
                    begin
                        cls = CLS_CONST;
                    end
                end
                default: cls = CLS_TEXT;
            endcase
            emit(tok_start, end_pos - tok_start, cls);
            tok_kind = KIND_IDLE;
        end
    endtask

    task automatic open_token(input logic [BYTE_W-1:0] c, input logic [POS_W-1:0] p);
        case (group_of(c))
            G_QUOTE:
            begin
                tok_kind  = KIND_STRING;
                tok_start = p;
                in_escape = 1'b0;
            end
            G_DIGIT:
            begin
                tok_kind  = KIND_NUMBER;
                tok_start = p;
            end
            G_MINUS: held_minus = 1'b1;
            G_WORD:
            begin
                tok_kind  = KIND_WORD;
                tok_start = p;
                word_bits = {32'h0, c};
                word_len  = 3'd1;
            end
            G_BRACKET: emit(p, 20'd1, CLS_PUNCT);
            G_OPER:    emit(p, 20'd1, CLS_OPER);
            default:
            begin
                tok_kind  = KIND_TEXT;
                tok_start = p;
            end
        endcase
    endtask

    task automatic text_step(input logic [BYTE_W-1:0] c, input logic [POS_W-1:0] p);
        byte_group_t g;
        g = group_of(c);
        if (g == G_MINUS)
            held_minus = 1'b1;
        else if (g != G_OTHER)
        begin
            close_open(p);
            open_token(c, p);
        end
    endtask

    task automatic lex(input logic [BYTE_W-1:0] c, input logic [POS_W-1:0] p);
        logic [POS_W-1:0] mpos;
        byte_group_t      g;
        g = group_of(c);
        if (held_minus)
        begin
            // The minus one byte back becomes a number only if a digit follows.
            mpos       = p - 20'd1;
            held_minus = 1'b0;
            if (g == G_DIGIT)
            begin
                if (tok_kind == KIND_TEXT)
                    close_open(mpos);
                tok_kind  = KIND_NUMBER;
                tok_start = mpos;
            end
            else
            begin
                if (tok_kind != KIND_TEXT)
                begin
                    tok_kind  = KIND_TEXT;
                    tok_start = mpos;
                end
                text_step(c, p);
            end
        end
        else
        begin
            case (tok_kind)
                KIND_STRING:
                begin
                    if (in_escape)
                        in_escape = 1'b0;
                    else if (c == CH_BACKSLASH)
                        in_escape = 1'b1;
                    else if (c == CH_QUOTE)
                        close_open(p + 20'd1);
                end
                KIND_NUMBER:
                begin
                    if (!(g == G_DIGIT || c == CH_DOT || c == CH_E_LOWER || c == CH_E_UPPER
                          || c == CH_PLUS || c == CH_MINUS))
                    begin
                        close_open(p);
                        open_token(c, p);
                    end
                end
                KIND_WORD:
                begin
                    if (g == G_WORD)
                    begin
                        if (word_len < WLEN_FIVE)
                            word_bits = {word_bits[PREFIX_W-9:0], c};
                        if (word_len < WLEN_SAT)
                            word_len++;
                    end
                    else
                    begin
                        close_open(p);
                        open_token(c, p);
                    end
                end
                KIND_TEXT: text_step(c, p);
                default:   open_token(c, p);
            endcase
        end
    endtask

    task automatic restart_line();
        tok_kind   = KIND_IDLE;
        tok_start  = '0;
        pos        = '0;
        in_escape  = 1'b0;
        held_minus = 1'b0;
        word_bits  = '0;
        word_len   = '0;
        line_spans = '0;
    endtask

    task automatic predict_spans(input logic [BYTE_W-1:0] c, input logic [POS_W-1:0] len);
        logic [POS_W-1:0] p;
        logic             long_line;
        logic             line_end;
        span_t            s;
        p          = pos;
        long_line  = len >= LONG_LINE_LIMIT;
        line_end   = ({1'b0, p} + 21'd1) >= {1'b0, len};
        step_count = 0;
        if (!long_line)
            lex(c, p);
        if (line_end)
        begin
            if (long_line)
                emit('0, len, CLS_TEXT);
            else
            begin
                // A minus on the final byte has nothing to follow it and is text.
                if (held_minus)
                begin
                    held_minus = 1'b0;
                    if (tok_kind != KIND_TEXT)
                    begin
                        tok_kind  = KIND_TEXT;
                        tok_start = p;
                    end
                end
                close_open(p + 20'd1);
            end
            restart_line();
        end
        else
            pos = p + 20'd1;
        for (int i = 0; i < step_count; i++)
        begin
            s      = step_spans[i];
            s.last = (i == step_count - 1);
            pending_spans.push_back(s);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_cap = SPAN_LIMIT_RESET;
            restart_line();
            pending_spans.delete();
        end
        else
        begin
            if (cfg_wr_en)
                span_cap = cfg_wr_data;
            if (s_tvalid && s_tready)
                predict_spans(s_tdata[7:0], s_tdata[27:8]);
            if (m_tvalid && m_tready)
            begin
                if (pending_spans.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: span beat with none expected, got start %0d length %0d ",
                             $time, m_tdata[13:0], m_tdata[33:14],
                             "class %0d last %0d", m_tdata[36:34], m_tlast);
                end
                else
                begin
                    oldest = pending_spans.pop_front();
                    if (m_tdata[13:0] != oldest.start || m_tdata[33:14] != oldest.length
                        || m_tdata[36:34] != oldest.cls || m_tlast != oldest.last)
                    begin
                        mismatches++;
                        $display("%0t: span mismatch, expected start %0d length %0d ",
                                 $time, oldest.start, oldest.length,
                                 "class %0d last %0d, got start %0d length %0d ",
                                 oldest.cls, oldest.last, m_tdata[13:0], m_tdata[33:14],
                                 "class %0d last %0d", m_tdata[36:34], m_tlast);
                    end
                end
            end
        end
        spans_due <= pending_spans.size();
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

// Testbench top for the JSON line tokenizer. This module only makes stimulus
// and gives the verdict; span_checker, instantiated beside the block, predicts
// and compares every span beat.
module tb;
    import jtc_pkg::*;

    localparam int LONG_LINE_LIMIT        = 16384;
    localparam int RANDOM_BYTES_PER_PHASE = 265;
    // Extra cycles after the last expected span before the block counts as idle.
    // A byte may cause no span at all and still has to pass the input register and lexer.
    localparam int IDLE_GUARD = 8;

    // How the line length field is sent with the bytes of one line.
    typedef enum int {
        LEN_TRUE,   // every byte carries the true length
        LEN_SHORT,  // one byte carries a length from zero up to just past the size
        LEN_HUGE    // one byte carries a length at or above the long-line limit
    } len_mode_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]     cfg_wr_data = '0;
    int                     mismatches;
    int                     spans_due;

    // Bytes of the line being built, and a running count of accepted bytes.
    logic [7:0]             line_buf [$];
    int                     bytes_sent   = 0;
    // The sender alternates stretches of random gaps with stretches of none.
    int                     send_stretch = 0;
    bit                     send_calm    = 1'b0;

    json_token_classifier #(
        .LONG_LINE_LIMIT(LONG_LINE_LIMIT)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    span_checker #(
        .LONG_LINE_LIMIT(LONG_LINE_LIMIT)
    ) span_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .mismatches (mismatches),
        .spans_due  (spans_due)
    );

    always #5 clk = ~clk;

    // Offers one byte after a random gap and returns at the edge where the
    // beat is taken. Every call starts and ends on a rising edge, and valid is
    // touched at most once per edge: it stays high across back-to-back beats.
    task automatic feed_byte(input logic [7:0] c, input logic [19:0] len);
        int gap;
        if (send_stretch == 0)
        begin
            send_stretch = $urandom_range(10, 60);
            send_calm    = ($urandom_range(0, 3) == 0);
        end
        send_stretch--;
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, len, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends the line in line_buf. The odd modes bend the length of one byte,
    // which can end the line early (a zero length among them), or make a
    // single byte look like part of a long line so the block skips lexing it.
    task automatic feed_line(input len_mode_t mode);
        int          n;
        int          odd_at;
        logic [19:0] len;
        n      = line_buf.size();
        odd_at = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            len = 20'(n);
            if (i == odd_at && mode == LEN_SHORT)
                len = 20'($urandom_range(0, n + 2));
            else if (i == odd_at && mode == LEN_HUGE)
                len = 20'($urandom_range(LONG_LINE_LIMIT, 20'hFFFFF));
            feed_byte(line_buf[i], len);
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // A string, mostly closed, with escapes that often hide a quote.
    task automatic add_string();
        int         n;
        logic [7:0] ch;
        n = $urandom_range(0, 6);
        line_buf.push_back(CH_QUOTE);
        repeat (n)
        begin
            ch = 8'($urandom_range(8'h20, 8'h7E));
            if ($urandom_range(0, 5) == 0)
            begin
                line_buf.push_back(CH_BACKSLASH);
                if ($urandom_range(0, 1) == 1)
                    ch = CH_QUOTE;
            end
            else if (ch == CH_QUOTE || ch == CH_BACKSLASH)
                ch = "x";
            line_buf.push_back(ch);
        end
        if ($urandom_range(0, 9) != 0)
            line_buf.push_back(CH_QUOTE);
    endtask

    task automatic add_digits(input int lo, input int hi);
        logic [7:0] d;
        repeat ($urandom_range(lo, hi))
        begin
            d = 8'h30 + 8'($urandom_range(0, 9));
            line_buf.push_back(d);
        end
    endtask

    // A number with optional sign, fraction and exponent.
    task automatic add_number();
        if ($urandom_range(0, 2) == 0)
            line_buf.push_back(CH_MINUS);
        add_digits(1, 4);
        if ($urandom_range(0, 2) == 0)
        begin
            line_buf.push_back(CH_DOT);
            add_digits(1, 3);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            line_buf.push_back($urandom_range(0, 1) ? CH_E_LOWER : CH_E_UPPER);
            if ($urandom_range(0, 1) == 1)
                line_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            add_digits(1, 2);
        end
    endtask

    // The three constants, words that nearly match them, and random words,
    // some long enough to saturate the word length counter.
    task automatic add_word();
        string w;
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyzTFNE_";
        case ($urandom_range(0, 9))
            0:       w = "true";
            1:       w = "false";
            2:       w = "null";
            3:       w = "tru";
            4:       w = "falsey";
            5:       w = "False";
            6:       w = "nul_";
            default:
            begin
                w = "";
                repeat ($urandom_range(1, 8))
                    w = {w, pool.substr($urandom_range(0, pool.len() - 1), 0)};
            end
        endcase
        add_text(w);
    endtask

    // Bytes that only form text runs, a lone minus, dot and plus among them.
    task automatic add_filler();
        string pool;
        int    k;
        pool = " \t!#$%&'()*/;<=>?@\\^`|~.+-";
        repeat ($urandom_range(1, 3))
        begin
            k = $urandom_range(0, pool.len() - 1);
            line_buf.push_back(pool[k]);
        end
    endtask

    task automatic add_token();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0:       add_string();
            1:       add_number();
            2, 3:    add_word();
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       b = CH_LBRACE;
                    1:       b = CH_RBRACE;
                    2:       b = CH_LBRACKET;
                    default: b = CH_RBRACKET;
                endcase
                line_buf.push_back(b);
            end
            5:       line_buf.push_back($urandom_range(0, 1) ? CH_COLON : CH_COMMA);
            6:       add_filler();
            7:
            begin
                // A minus that no digit follows.
                line_buf.push_back(CH_MINUS);
                if ($urandom_range(0, 1) == 1)
                    add_word();
                else
                    add_filler();
            end
            default:
            begin
                b = 8'($urandom_range(0, 255));
                line_buf.push_back(b);
            end
        endcase
    endtask

    // Idle point for register writes: no span outstanding, and enough further
    // cycles for a byte that causes no span to leave the pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (spans_due != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    task automatic write_span_limit(input logic [LIMIT_W-1:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One register setting, then random lines. Most lines are well-formed
    // objects with random content; the rest are loose token soup and raw bytes.
    task automatic run_phase(input logic [LIMIT_W-1:0] limit);
        int        target;
        int        shape;
        int        pairs;
        int        r;
        len_mode_t mode;
        settle();
        write_span_limit(limit);
        target = bytes_sent + RANDOM_BYTES_PER_PHASE;
        while (bytes_sent < target)
        begin
            line_buf.delete();
            shape = $urandom_range(0, 9);
            if (shape < 6)
            begin
                pairs = $urandom_range(1, 3);
                line_buf.push_back(CH_LBRACE);
                for (int k = 0; k < pairs; k++)
                begin
                    if (k > 0)
                        line_buf.push_back(CH_COMMA);
                    add_string();
                    line_buf.push_back(CH_COLON);
                    if ($urandom_range(0, 1) == 1)
                        line_buf.push_back(" ");
                    case ($urandom_range(0, 4))
                        0: add_string();
                        1: add_number();
                        2: add_word();
                        3:
                        begin
                            line_buf.push_back(CH_LBRACKET);
                            add_number();
                            line_buf.push_back(CH_COMMA);
                            add_token();
                            line_buf.push_back(CH_RBRACKET);
                        end
                        default: add_token();
                    endcase
                end
                line_buf.push_back(CH_RBRACE);
            end
            else if (shape < 9)
            begin
                repeat ($urandom_range(1, 8))
                    add_token();
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            r = $urandom_range(0, 9);
            if (r < 7)
                mode = LEN_TRUE;
            else if (r < 9)
                mode = LEN_SHORT;
            else
                mode = LEN_HUGE;
            feed_line(mode);
        end
    endtask

    // Receiver: random stalls before each beat, in stretches with and without
    // stalls. Twice it holds off for a long time on its own count of cycles
    // while the sender keeps offering, so the span queue fills and the block
    // has to stall its input.
    initial
    begin
        int gap;
        int stretch;
        bit calm;
        int beats;
        stretch = 0;
        calm    = 1'b0;
        beats   = 0;
        @(posedge rst_n);
        forever
        begin
            if (stretch == 0)
            begin
                stretch = $urandom_range(10, 60);
                calm    = ($urandom_range(0, 3) == 0);
            end
            stretch--;
            gap = calm ? 0 : $urandom_range(0, 11);
            if (beats == 40 || beats == 250)
                gap = 400;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            beats++;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset span limit: braces, a string holding an
        // escaped quote, operators, a negative number with exponent and a
        // constant; a text run that ends in a minus at the line end; a string
        // left open at the line end; a zero line length; and a NUL byte.
        add_text("{\"a\\\"\":-1e+5,true}");
        feed_line(LEN_TRUE);
        line_buf.delete();
        add_text("x-");
        feed_line(LEN_TRUE);
        line_buf.delete();
        add_text("\"q");
        feed_line(LEN_TRUE);
        feed_byte(8'hFF, 20'd0);
        feed_byte(8'h00, 20'd1);

        // Random phases over several span limits, the extremes among them.
        run_phase(16'hFFFF);
        run_phase(16'd1);
        run_phase(16'd0);
        run_phase(16'd2);
        run_phase(LIMIT_W'($urandom_range(3, 6)));
        run_phase(SPAN_LIMIT_RESET);

        settle();
        if (mismatches == 0 && spans_due == 0)
            $display("json_token_classifier test passed");
        else
            $display("json_token_classifier test failed");
        $finish;
    end

    // Watchdog. The slowest correct run is about 1.7k bytes, each offered after
    // a random gap and causing at most two spans that each wait on a random
    // receiver gap, plus two long receiver holds; the timeout allows several
    // times that.
    initial
    begin
        #5_000_000;
        $display("json_token_classifier test failed");
        $finish;
    end

endmodule
